[src/slcd_pkg.sv]
// Package with the reply codes, match patterns and widths of the serial line command decoder.
package slcd_pkg;

  typedef enum logic [1:0] {
    REPLY_PONG = 2'd0,
    REPLY_OK   = 2'd1,
    REPLY_ERR  = 2'd2
  } reply_code_t;

  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_ONE  = 8'h31;

  // Text length saturates once no pattern can still match.
  localparam int TEXT_LEN_W = 5;
  localparam logic [TEXT_LEN_W-1:0] PING_LEN      = 5'd4;
  localparam logic [TEXT_LEN_W-1:0] STATE_LEN     = 5'd25;
  localparam logic [TEXT_LEN_W-1:0] BEAMS_POS     = 5'd12;
  localparam logic [TEXT_LEN_W-1:0] RADIATION_POS = 5'd24;
  localparam logic [TEXT_LEN_W-1:0] TEXT_LEN_SAT  = 5'd26;

  // "PING", one character per position.
  function automatic logic [7:0] ping_char(input logic [1:0] pos);
    logic [7:0] ch;
    case (pos)
      2'd0:    ch = 8'h50;
      2'd1:    ch = 8'h49;
      2'd2:    ch = 8'h4E;
      default: ch = 8'h47;
    endcase
    return ch;
  endfunction

  // "STATE beams=0 radiation=0"; the digit positions are checked separately.
  function automatic logic [7:0] state_char(input logic [TEXT_LEN_W-1:0] pos);
    logic [7:0] ch;
    case (pos)
      5'd0:    ch = 8'h53;
      5'd1:    ch = 8'h54;
      5'd2:    ch = 8'h41;
      5'd3:    ch = 8'h54;
      5'd4:    ch = 8'h45;
      5'd5:    ch = 8'h20;
      5'd6:    ch = 8'h62;
      5'd7:    ch = 8'h65;
      5'd8:    ch = 8'h61;
      5'd9:    ch = 8'h6D;
      5'd10:   ch = 8'h73;
      5'd11:   ch = 8'h3D;
      5'd12:   ch = 8'h30;
      5'd13:   ch = 8'h20;
      5'd14:   ch = 8'h72;
      5'd15:   ch = 8'h61;
      5'd16:   ch = 8'h64;
      5'd17:   ch = 8'h69;
      5'd18:   ch = 8'h61;
      5'd19:   ch = 8'h74;
      5'd20:   ch = 8'h69;
      5'd21:   ch = 8'h6F;
      5'd22:   ch = 8'h6E;
      5'd23:   ch = 8'h3D;
      5'd24:   ch = 8'h30;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

[src/serial_line_command_decoder_unit.sv]
// Top level of the serial line command decoder: line assembly, pattern matching and reply output.
//
// The block takes received serial bytes on the slave stream, one request per byte, and
// answers finished command lines on the master stream. A carriage return is skipped, a
// newline ends the line and a NUL ends its text. A line whose text is exactly "PING" is
// answered PONG, one whose text is exactly "STATE beams=X radiation=Y" (X, Y each 0 or 1)
// latches both levels and is answered OK, an empty line gets no answer, and anything else,
// or a line longer than LINE_CAPACITY-1 characters, is answered ERR. Each answer carries
// the currently latched levels. Matching runs on the fly, one character per accepted byte,
// so one byte is taken in every cycle while the skid register is empty, and the answer to
// a newline goes to the reply register, or to the skid register while the master side stalls.
// The rate is set by the single matching step between the slave port and the reply register.
// A reply register and a one-entry skid register sit on the master side, so bytes keep
// flowing while one reply waits to be taken; only when a second reply has to wait as
// well does tready drop on the slave side until the master side drains.
// Synchronous reset clears the line state, both latched levels and all pending replies.
module serial_line_command_decoder_unit #(
  parameter int LINE_CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,  // [7:0] rx_byte
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata   // [1:0] reply_code, [2] beams_level,
                                    // [3] radiation_level, [7:4] zero
);

  localparam int CountW = $clog2(LINE_CAPACITY);
  localparam logic [CountW-1:0] CountMax = CountW'(LINE_CAPACITY - 1);
  localparam int TlW = slcd_pkg::TEXT_LEN_W;

  // Line state.
  logic [CountW-1:0] char_count;
  logic [TlW-1:0]    text_length;
  logic              overflow_flag;
  logic              text_ended;
  logic              ping_alive;
  logic              state_alive;
  logic              beams_digit;
  logic              radiation_digit;
  logic              beams_out;
  logic              radiation_out;

  // Reply register and skid register.
  logic       reply_valid;
  logic [7:0] reply_data;
  logic       skid_valid;
  logic [7:0] skid_data;

  logic       accept;
  logic [7:0] rx_byte;
  logic       is_cr;
  logic       is_lf;
  logic       is_digit;
  logic       ping_ok;
  logic       state_ok;
  logic       res_valid;
  logic [7:0] res_data;
  logic       latch_levels;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rx_byte       = s_axis_tdata;
  assign is_cr         = (rx_byte == slcd_pkg::CHAR_CR);
  assign is_lf         = (rx_byte == slcd_pkg::CHAR_LF);
  assign is_digit      = (rx_byte == slcd_pkg::CHAR_ZERO) || (rx_byte == slcd_pkg::CHAR_ONE);

  // Does this character continue each pattern at the current text position?
  always_comb begin
    ping_ok = (text_length < slcd_pkg::PING_LEN) &&
              (rx_byte == slcd_pkg::ping_char(text_length[1:0]));
    if (text_length >= slcd_pkg::STATE_LEN) begin
      state_ok = 1'b0;
    end else if (text_length == slcd_pkg::BEAMS_POS ||
                 text_length == slcd_pkg::RADIATION_POS) begin
      state_ok = is_digit;
    end else begin
      state_ok = (rx_byte == slcd_pkg::state_char(text_length));
    end
  end

  // Reply to a newline, if it gets one.
  always_comb begin
    slcd_pkg::reply_code_t code;
    logic beams_new;
    logic radiation_new;
    code          = slcd_pkg::REPLY_ERR;
    res_valid     = 1'b0;
    latch_levels  = 1'b0;
    beams_new     = beams_out;
    radiation_new = radiation_out;
    if (accept && is_lf) begin
      if (overflow_flag) begin
        res_valid = 1'b1;
      end else if (char_count != '0) begin
        res_valid = 1'b1;
        if (ping_alive && text_length == slcd_pkg::PING_LEN) begin
          code = slcd_pkg::REPLY_PONG;
        end else if (state_alive && text_length == slcd_pkg::STATE_LEN) begin
          code          = slcd_pkg::REPLY_OK;
          latch_levels  = 1'b1;
          beams_new     = beams_digit;
          radiation_new = radiation_digit;
        end
      end
    end
    res_data = {4'b0000, radiation_new, beams_new, code};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_count      <= '0;
      text_length     <= '0;
      overflow_flag   <= 1'b0;
      text_ended      <= 1'b0;
      ping_alive      <= 1'b1;
      state_alive     <= 1'b1;
      beams_digit     <= 1'b0;
      radiation_digit <= 1'b0;
      beams_out       <= 1'b0;
      radiation_out   <= 1'b0;
    end else if (accept && !is_cr) begin
      if (is_lf) begin
        // Start a new line; levels change only on a valid STATE line.
        if (latch_levels) begin
          beams_out     <= beams_digit;
          radiation_out <= radiation_digit;
        end
        char_count      <= '0;
        text_length     <= '0;
        overflow_flag   <= 1'b0;
        text_ended      <= 1'b0;
        ping_alive      <= 1'b1;
        state_alive     <= 1'b1;
        beams_digit     <= 1'b0;
        radiation_digit <= 1'b0;
      end else if (char_count < CountMax) begin
        char_count <= char_count + 1'b1;
        if (!text_ended) begin
          if (rx_byte == slcd_pkg::CHAR_NUL) begin
            text_ended <= 1'b1;
          end else begin
            if (!ping_ok) begin
              ping_alive <= 1'b0;
            end
            if (!state_ok) begin
              state_alive <= 1'b0;
            end
            if (is_digit && text_length == slcd_pkg::BEAMS_POS) begin
              beams_digit <= (rx_byte == slcd_pkg::CHAR_ONE);
            end
            if (is_digit && text_length == slcd_pkg::RADIATION_POS) begin
              radiation_digit <= (rx_byte == slcd_pkg::CHAR_ONE);
            end
            // Past the longest pattern the exact length no longer matters.
            if (text_length != slcd_pkg::TEXT_LEN_SAT) begin
              text_length <= text_length + 1'b1;
            end
          end
        end
      end else begin
        overflow_flag <= 1'b1;
      end
    end
  end

  // Output side: the reply register feeds the port, the skid register catches a reply
  // that arrives while the port is stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      reply_valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (m_axis_tready || !reply_valid) begin
      if (skid_valid) begin
        reply_valid <= 1'b1;
        reply_data  <= skid_data;
        skid_valid  <= 1'b0;
      end else begin
        reply_valid <= res_valid;
        if (res_valid) begin
          reply_data <= res_data;
        end
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
      skid_data  <= res_data;
    end
  end

  assign m_axis_tvalid = reply_valid;
  assign m_axis_tdata  = reply_data;

endmodule

[src/slcd_checker.sv]
// Port-level checker for the serial line command decoder and its bind statement.
module slcd_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic [7:0] s_axis_tdata,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // A reply never carries the unused code or stray upper bits.
  a_reply_code_legal : assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3) && (m_axis_tdata[7:4] == 4'd0))
    else $error("reply carries an illegal code");

  // Only a newline can produce a reply on an idle output.
  a_no_reply_without_newline : assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tdata != slcd_pkg::CHAR_LF) &&
     !m_axis_tvalid) |=> !m_axis_tvalid)
    else $error("reply appeared without a newline");

  // After reset the byte side is open and no reply is pending.
  a_reset_state : assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not idle after reset");

  // A stalled reply holds.
  a_reply_holds : assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled reply changed");

endmodule

bind serial_line_command_decoder_unit slcd_checker u_slcd_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

[dv/tb_serial_line_command_decoder_unit.sv]
// Self-checking testbench for the serial line command decoder unit.
module tb_serial_line_command_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_CAPACITY = 64;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int BYTES_PER_PHASE = 200;
  localparam int SETTLE_CYCLES = 16;

  // Command patterns, first character in the top byte. The STATE digits are
  // placeholders; those two positions accept either digit.
  localparam int PING_CHARS   = 4;
  localparam int STATE_CHARS  = 25;
  localparam int BEAMS_AT     = 12;
  localparam int RADIATION_AT = 24;
  localparam logic [8*PING_CHARS-1:0]  PING_TEXT  = "PING";
  localparam logic [8*STATE_CHARS-1:0] STATE_TEXT = "STATE beams=0 radiation=0";

  typedef struct {
    slcd_pkg::reply_code_t code;
    logic                  beams;
    logic                  radiation;
  } line_reply_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;   // [7:0] rx_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [1:0] reply_code, [2] beams_level,
                                      // [3] radiation_level, [7:4] zero

  serial_line_command_decoder_unit #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always #1 clk = ~clk;

  // Bytes waiting to be sent, and replies the decoder still owes us.
  logic [7:0]  rx_backlog[$];
  logic [7:0]  line_buf[$];
  line_reply_t expected_replies[$];

  int unsigned items_queued = 0;
  int unsigned items_taken  = 0;
  int unsigned lines_sent   = 0;
  int unsigned error_count  = 0;
  int unsigned pong_seen = 0, ok_seen = 0, err_seen = 0;
  int unsigned cycle_count  = 0;
  int unsigned gap_pct   = 0;
  int unsigned stall_pct = 0;

  // Shadow copy of the decoder's line state and latched levels.
  int   line_chars      = 0;
  int   text_len        = 0;
  logic line_overflow   = 1'b0;
  logic text_done       = 1'b0;
  logic ping_ok         = 1'b1;
  logic state_ok        = 1'b1;
  logic beams_digit     = 1'b0;
  logic radiation_digit = 1'b0;
  logic beams_level     = 1'b0;
  logic radiation_level = 1'b0;

  // Advances the shadow decoder by one received byte and records the reply
  // that a finished line is owed.
  function automatic void decode_rx_byte(input logic [7:0] b);
    line_reply_t r;
    logic        emit;
    if (b == slcd_pkg::CHAR_CR) begin
      return;
    end
    if (b != slcd_pkg::CHAR_LF) begin
      if (line_chars < LINE_CAPACITY - 1) begin
        line_chars++;
        // Once a NUL has been seen the rest of the line is counted but not matched.
        if (!text_done && b == slcd_pkg::CHAR_NUL) begin
          text_done = 1'b1;
        end else if (!text_done) begin
          if (text_len < PING_CHARS) begin
            if (b != PING_TEXT[8*(PING_CHARS-1-text_len) +: 8]) ping_ok = 1'b0;
          end else begin
            ping_ok = 1'b0;
          end
          if (text_len >= STATE_CHARS) begin
            state_ok = 1'b0;
          end else if (text_len == BEAMS_AT || text_len == RADIATION_AT) begin
            if (b == slcd_pkg::CHAR_ZERO || b == slcd_pkg::CHAR_ONE) begin
              if (text_len == BEAMS_AT) beams_digit = (b == slcd_pkg::CHAR_ONE);
              else radiation_digit = (b == slcd_pkg::CHAR_ONE);
            end else begin
              state_ok = 1'b0;
            end
          end else if (b != STATE_TEXT[8*(STATE_CHARS-1-text_len) +: 8]) begin
            state_ok = 1'b0;
          end
          text_len++;
        end
      end else begin
        line_overflow = 1'b1;
      end
      return;
    end

    // Newline: decide the reply, then start a fresh line.
    emit = 1'b1;
    if (line_overflow) begin
      r.code = slcd_pkg::REPLY_ERR;
    end else if (line_chars == 0) begin
      emit = 1'b0;
    end else if (ping_ok && text_len == PING_CHARS) begin
      r.code = slcd_pkg::REPLY_PONG;
    end else if (state_ok && text_len == STATE_CHARS) begin
      beams_level     = beams_digit;
      radiation_level = radiation_digit;
      r.code = slcd_pkg::REPLY_OK;
    end else begin
      r.code = slcd_pkg::REPLY_ERR;
    end
    if (emit) begin
      r.beams     = beams_level;
      r.radiation = radiation_level;
      expected_replies.push_back(r);
    end
    line_chars      = 0;
    text_len        = 0;
    line_overflow   = 1'b0;
    text_done       = 1'b0;
    ping_ok         = 1'b1;
    state_ok        = 1'b1;
    beams_digit     = 1'b0;
    radiation_digit = 1'b0;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      line_buf.push_back(s[i]);
    end
  endtask

  // Hands the assembled line to the driver, optionally with a CR before the LF.
  task automatic end_line(input bit with_cr);
    if (with_cr) line_buf.push_back(slcd_pkg::CHAR_CR);
    line_buf.push_back(slcd_pkg::CHAR_LF);
    foreach (line_buf[i]) rx_backlog.push_back(line_buf[i]);
    items_queued += line_buf.size();
    lines_sent++;
    line_buf.delete();
  endtask

  // Sender: keeps tvalid up until the byte is taken, then loads the next one
  // unless this cycle is drawn as a gap. Accepted bytes feed the predictor.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_rx_byte(s_axis_tdata);
        items_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (rx_backlog.size() != 0 && $urandom_range(99) >= gap_pct) begin
          s_axis_tdata  <= rx_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure.
  always @(posedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // Reply checker: every accepted reply must match the oldest one owed.
  always @(posedge clk) begin : reply_check
    line_reply_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_replies.size() == 0) begin
        error_count++;
        $display("%0t: unexpected reply, expected none, got tdata=%h", $time, m_axis_tdata);
      end else begin
        want = expected_replies.pop_front();
        case (want.code)
          slcd_pkg::REPLY_PONG: pong_seen++;
          slcd_pkg::REPLY_OK:   ok_seen++;
          default:              err_seen++;
        endcase
        if (m_axis_tdata[1:0] !== want.code || m_axis_tdata[2] !== want.beams ||
            m_axis_tdata[3] !== want.radiation || m_axis_tdata[7:4] !== 4'h0) begin
          error_count++;
          $display({"%0t: reply mismatch, expected code=%0d beams=%0b radiation=%0b pad=0,",
                    " got code=%0d beams=%0b radiation=%0b pad=%h"},
                   $time, want.code, want.beams, want.radiation, m_axis_tdata[1:0],
                   m_axis_tdata[2], m_axis_tdata[3], m_axis_tdata[7:4]);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned phase_start;
    int unsigned shape;
    int unsigned idx;
    int unsigned len;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 72; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 72; end
        default: begin gap_pct = 28; stall_pct = 28; end
      endcase

      if (phase == 0) begin
        // Directed lines: blank lines, both commands with every digit pair,
        // stray CRs, NUL-terminated text, near misses and the capacity edge.
        end_line(1'b0);
        end_line(1'b1);
        push_text("PING"); end_line(1'b0);
        push_text("STATE beams=1 radiation=0"); end_line(1'b0);
        push_text("PI"); line_buf.push_back(slcd_pkg::CHAR_CR); push_text("NG");
        end_line(1'b1);
        push_text("STATE beams=0 radiation=1"); end_line(1'b0);
        push_text("STATE beams=1 radiation=1"); end_line(1'b1);
        push_text("PING"); line_buf.push_back(slcd_pkg::CHAR_NUL); line_buf.push_back(8'hFF);
        push_text("x"); end_line(1'b0);
        line_buf.push_back(slcd_pkg::CHAR_NUL); end_line(1'b0);
        line_buf.push_back(slcd_pkg::CHAR_NUL); push_text("PING"); end_line(1'b0);
        push_text("PIN"); end_line(1'b0);
        push_text("PINGG"); end_line(1'b0);
        push_text("ping"); end_line(1'b0);
        push_text("STATE beams=2 radiation=0"); end_line(1'b0);
        push_text("STATE beams=1 radiation=1X"); end_line(1'b0);
        push_text("STATE beams=0 radiation="); end_line(1'b0);
        // Exactly capacity-1 characters: accepted without overflow but not a command.
        repeat (LINE_CAPACITY - 1) line_buf.push_back(8'h41);
        end_line(1'b0);
        // PING with a NUL and padding up to the last free slot still matches.
        push_text("PING"); line_buf.push_back(slcd_pkg::CHAR_NUL);
        repeat (LINE_CAPACITY - 6) line_buf.push_back(8'h5A);
        end_line(1'b0);
        // One byte more overflows, and a CR after the overflow changes nothing.
        push_text("PING"); line_buf.push_back(slcd_pkg::CHAR_NUL);
        repeat (LINE_CAPACITY - 5) line_buf.push_back(8'h5A);
        end_line(1'b1);
        line_buf.push_back(8'hFF); line_buf.push_back(8'h80); end_line(1'b0);
        push_text("STATE beams=0 radiation=0"); end_line(1'b0);
      end

      // Random lines, mostly well-formed commands with random digits, the
      // rest mutated commands, noise, blank lines and lines around the capacity.
      phase_start = items_queued;
      while (items_queued - phase_start < BYTES_PER_PHASE) begin
        shape = $urandom_range(99);
        if (shape < 30) begin
          push_text("PING");
        end else if (shape < 65) begin
          push_text("STATE beams=");
          line_buf.push_back($urandom_range(1) ? slcd_pkg::CHAR_ONE : slcd_pkg::CHAR_ZERO);
          push_text(" radiation=");
          line_buf.push_back($urandom_range(1) ? slcd_pkg::CHAR_ONE : slcd_pkg::CHAR_ZERO);
        end else if (shape < 80) begin
          if ($urandom_range(1)) push_text("PING");
          else push_text("STATE beams=1 radiation=0");
          idx = $urandom_range(line_buf.size() - 1);
          case ($urandom_range(4))
            0: line_buf[idx] = 8'($urandom_range(255));
            1: repeat ($urandom_range(1, line_buf.size() - 1)) void'(line_buf.pop_back());
            2: line_buf.push_back(8'($urandom_range(255)));
            3: line_buf.insert(idx, slcd_pkg::CHAR_NUL);
            default: line_buf.insert(idx, slcd_pkg::CHAR_CR);
          endcase
        end else if (shape < 90) begin
          repeat ($urandom_range(1, 8)) line_buf.push_back(8'($urandom_range(255)));
        end else if (shape >= 95) begin
          // Lengths straddle the capacity so both sides of the overflow edge occur.
          len = $urandom_range(LINE_CAPACITY - 6, LINE_CAPACITY + 4);
          if ($urandom_range(1)) begin
            push_text("PING");
            line_buf.push_back(slcd_pkg::CHAR_NUL);
          end
          while (line_buf.size() < len) line_buf.push_back(8'($urandom_range(32, 126)));
        end
        end_line($urandom_range(4) == 0);
      end

      // Wait until every byte of this phase is taken and every reply has come back.
      while (!(items_taken == items_queued && expected_replies.size() == 0)) begin
        @(posedge clk);
      end
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_replies.size() != 0) begin
      error_count++;
      $display("%0t: %0d replies never arrived", $time, expected_replies.size());
    end

    $display("Sent %0d bytes in %0d lines over four flow-control phases.", items_taken,
             lines_sent);
    $display("Checked replies: %0d PONG, %0d OK, %0d ERR; %0d errors.", pong_seen, ok_seen,
             err_seen, error_count);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
